@@ rtl/fbba_pkg.sv @@
package fbba_pkg;

   localparam int MAX_BLOCKS = 1024;
   localparam int WORD_BITS  = 32;
   localparam int MAP_WORDS  = MAX_BLOCKS / WORD_BITS;
   localparam int WORD_IDX_W = $clog2(MAP_WORDS);
   localparam int BIT_IDX_W  = $clog2(WORD_BITS);
   localparam int BLK_W      = 10;
   localparam int CNT_W      = 11;
   localparam int MODE_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_DISK_BLOCKS     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVED_BLOCKS = CSR_IDX_W'(1);

   typedef enum logic [MODE_W-1:0] {
      MODE_INIT  = 2'd0,
      MODE_MARK  = 2'd1,
      MODE_ALLOC = 2'd2,
      MODE_FREE  = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INIT,
      S_RMW_RD,
      S_RMW_WR,
      S_SCAN,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic init_step;
      logic rmw_read;
      logic rmw_write;
      logic scan;
      logic publish;
   } dp_cmd_type;

   typedef struct packed {
      logic in_range;
      logic no_blocks;
      logic init_last;
      logic scan_hit;
      logic scan_end;
      logic out_busy;
   } dp_stat_type;

endpackage

@@ rtl/free_block_bitmap_allocator.sv @@
// First-fit used-block bitmap allocator, one bit per disk block (1 = used).
// Request channel (req_valid/req_stall): req_mode selects init, mark-used,
// allocate or free; req_block_number names the block for mark-used and free.
// Response channel (rsp_valid/rsp_stall): one response per request, carrying
// rsp_allocated_block and rsp_status (ok, map full, block out of range).
// CSR channel (csr_valid/csr_ready, always ready): index 0 sets the disk size,
// index 1 the count of blocks that init reserves. Write only while idle.
// Work per request, accept to response: init writes one map word per cycle
// over all 32 words, mark-used/free do a read-modify-write of one word,
// out-of-range or empty-disk requests go straight to the response, and
// allocate reads one word per cycle through the map RAM, stopping at the
// first word with a free block. One request is in work at a time; the next
// is taken in the cycle after the response enters the output register.
// Reset clears the map to all free at once and sets disk size 1024 and one
// reserved block. A stalled response is held in the output register; a new
// request can still be taken and worked, and its response waits until the
// output register frees.
module free_block_bitmap_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [fbba_pkg::MODE_W-1:0]     req_mode,
   input  logic [fbba_pkg::BLK_W-1:0]      req_block_number,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [fbba_pkg::BLK_W-1:0]      rsp_allocated_block,
   output logic [fbba_pkg::STATUS_W-1:0]   rsp_status,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [fbba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fbba_pkg::CNT_W-1:0]      csr_data
);
   import fbba_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   fbba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .stat      (stat),
      .cmd       (cmd)
   );

   fbba_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_mode            (req_mode),
      .req_block_number    (req_block_number),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_allocated_block (rsp_allocated_block),
      .rsp_status          (rsp_status),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

endmodule

@@ rtl/fbba_ram.sv @@
module fbba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/fbba_datapath.sv @@
module fbba_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  fbba_pkg::dp_cmd_type            cmd,
   output fbba_pkg::dp_stat_type           stat,
   input  logic [fbba_pkg::MODE_W-1:0]     req_mode,
   input  logic [fbba_pkg::BLK_W-1:0]      req_block_number,
   input  logic                            rsp_stall,
   output logic                            rsp_valid,
   output logic [fbba_pkg::BLK_W-1:0]      rsp_allocated_block,
   output logic [fbba_pkg::STATUS_W-1:0]   rsp_status,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [fbba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fbba_pkg::CNT_W-1:0]      csr_data
);
   import fbba_pkg::*;

   localparam logic [CNT_W-1:0]     LIMIT_MAX = CNT_W'(MAX_BLOCKS);
   localparam logic [WORD_BITS-1:0] ONES      = '1;

   logic [CNT_W-1:0]      disk_ff, disk_in;
   logic [CNT_W-1:0]      rsv_ff, rsv_in;
   mode_type              mode_ff, mode_in;
   logic [BLK_W-1:0]      blk_ff, blk_in;
   logic [WORD_IDX_W-1:0] word_ff, word_in;
   logic                  issued_all_ff, issued_all_in;
   logic                  chk_ff, chk_in;
   logic [WORD_IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [MAP_WORDS-1:0]  valid_ff, valid_in;
   logic [BLK_W-1:0]      res_alloc_ff, res_alloc_in;
   status_type            res_status_ff, res_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BLK_W-1:0]      rsp_alloc_ff, rsp_alloc_in;
   status_type            rsp_status_ff, rsp_status_in;

   logic [CNT_W-1:0]      lim;
   logic [CNT_W-1:0]      lim_m1;
   logic [CNT_W-1:0]      rsv_eff;
   logic [WORD_IDX_W-1:0] last_word;
   logic                  in_range;
   logic                  issue;
   logic                  rd_en;
   logic [WORD_IDX_W-1:0] rd_addr;
   logic [WORD_BITS-1:0]  rd_data;
   logic [WORD_BITS-1:0]  word_eff;
   logic [WORD_BITS-1:0]  valid_mask;
   logic [WORD_BITS-1:0]  free_vec;
   logic [WORD_BITS-1:0]  low_onehot;
   logic [BIT_IDX_W-1:0]  low_idx;
   logic                  hit;
   logic [WORD_BITS-1:0]  init_mask;
   logic [WORD_BITS-1:0]  rmw_word;
   logic [CNT_W-BIT_IDX_W-1:0] rsv_hi;
   logic                  wr_en;
   logic [WORD_IDX_W-1:0] wr_addr;
   logic [WORD_BITS-1:0]  wr_data;

   always_comb begin
      lim       = (disk_ff > LIMIT_MAX) ? LIMIT_MAX : disk_ff;
      lim_m1    = lim - CNT_W'(1);
      last_word = lim_m1[BLK_W-1:BIT_IDX_W];
      if (rsv_ff == '0) begin
         rsv_eff = CNT_W'(1);
      end else if (rsv_ff > LIMIT_MAX) begin
         rsv_eff = LIMIT_MAX;
      end else begin
         rsv_eff = rsv_ff;
      end
      in_range = {1'b0, req_block_number} < lim;
   end

   assign issue   = cmd.scan && !issued_all_ff;
   assign rd_en   = issue || cmd.rmw_read;
   assign rd_addr = cmd.scan ? word_ff : blk_ff[BLK_W-1:BIT_IDX_W];

   fbba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAP_WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      word_eff   = valid_ff[rd_idx_ff] ? rd_data : '0;
      valid_mask = (rd_idx_ff == last_word) ?
                   (ONES >> (BIT_IDX_W'(WORD_BITS - 1) - lim_m1[BIT_IDX_W-1:0])) : ONES;
      free_vec   = ~word_eff & valid_mask;
      low_onehot = free_vec & (~free_vec + WORD_BITS'(1));
      low_idx    = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         low_idx = low_idx | (low_onehot[i] ? BIT_IDX_W'(i) : '0);
      end
      hit = chk_ff && (free_vec != '0);
   end

   always_comb begin
      rsv_hi = rsv_eff[CNT_W-1:BIT_IDX_W];
      if (rsv_hi > (CNT_W-BIT_IDX_W)'(word_ff)) begin
         init_mask = ONES;
      end else if (rsv_hi == (CNT_W-BIT_IDX_W)'(word_ff)) begin
         init_mask = ~(ONES << rsv_eff[BIT_IDX_W-1:0]);
      end else begin
         init_mask = '0;
      end
      rmw_word = word_eff;
      rmw_word[blk_ff[BIT_IDX_W-1:0]] = (mode_ff == MODE_MARK);
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rd_idx_ff;
      wr_data = rmw_word;
      if (cmd.init_step) begin
         wr_en   = 1'b1;
         wr_addr = word_ff;
         wr_data = init_mask;
      end else if (cmd.rmw_write) begin
         wr_en = 1'b1;
      end else if (cmd.scan && hit) begin
         wr_en   = 1'b1;
         wr_data = word_eff | low_onehot;
      end
   end

   always_comb begin
      disk_in       = disk_ff;
      rsv_in        = rsv_ff;
      mode_in       = mode_ff;
      blk_in        = blk_ff;
      word_in       = word_ff;
      issued_all_in = issued_all_ff;
      chk_in        = chk_ff;
      rd_idx_in     = rd_en ? rd_addr : rd_idx_ff;
      valid_in      = valid_ff;
      res_alloc_in  = res_alloc_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_alloc_in  = rsp_alloc_ff;
      rsp_status_in = rsp_status_ff;

      if (csr_valid) begin
         if (csr_index == CSR_DISK_BLOCKS) begin
            disk_in = csr_data;
         end else if (csr_index == CSR_RESERVED_BLOCKS) begin
            rsv_in = csr_data;
         end
      end

      if (cmd.accept) begin
         mode_in       = mode_type'(req_mode);
         blk_in        = req_block_number;
         word_in       = '0;
         issued_all_in = 1'b0;
         chk_in        = 1'b0;
         res_alloc_in  = '0;
         if (mode_type'(req_mode) == MODE_ALLOC) begin
            res_status_in = STATUS_FULL;
         end else if (mode_type'(req_mode) != MODE_INIT && !in_range) begin
            res_status_in = STATUS_RANGE;
         end else begin
            res_status_in = STATUS_OK;
         end
      end

      if (cmd.init_step) begin
         word_in           = word_ff + WORD_IDX_W'(1);
         valid_in[word_ff] = 1'b1;
      end

      if (cmd.rmw_write) begin
         valid_in[rd_idx_ff] = 1'b1;
      end

      if (cmd.scan) begin
         chk_in = issue;
         if (issue) begin
            word_in = word_ff + WORD_IDX_W'(1);
            if (word_ff == last_word) begin
               issued_all_in = 1'b1;
            end
         end
         if (hit) begin
            valid_in[rd_idx_ff] = 1'b1;
            res_alloc_in        = {rd_idx_ff, low_idx};
            res_status_in       = STATUS_OK;
         end
      end

      if (cmd.publish) begin
         rsp_valid_in  = 1'b1;
         rsp_alloc_in  = res_alloc_ff;
         rsp_status_in = res_status_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         disk_ff       <= LIMIT_MAX;
         rsv_ff        <= CNT_W'(1);
         word_ff       <= '0;
         issued_all_ff <= 1'b0;
         chk_ff        <= 1'b0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         disk_ff       <= disk_in;
         rsv_ff        <= rsv_in;
         word_ff       <= word_in;
         issued_all_ff <= issued_all_in;
         chk_ff        <= chk_in;
         valid_ff      <= valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      blk_ff        <= blk_in;
      rd_idx_ff     <= rd_idx_in;
      res_alloc_ff  <= res_alloc_in;
      res_status_ff <= res_status_in;
      rsp_alloc_ff  <= rsp_alloc_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      stat.in_range  = in_range;
      stat.no_blocks = (lim == '0);
      stat.init_last = (word_ff == WORD_IDX_W'(MAP_WORDS - 1));
      stat.scan_hit  = hit;
      stat.scan_end  = chk_ff && !hit && (rd_idx_ff == last_word);
      stat.out_busy  = rsp_valid_ff && rsp_stall;
   end

   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_allocated_block = rsp_alloc_ff;
   assign rsp_status          = rsp_status_ff;

endmodule

@@ rtl/fbba_ctrl.sv @@
module fbba_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [fbba_pkg::MODE_W-1:0]  req_mode,
   input  fbba_pkg::dp_stat_type        stat,
   output fbba_pkg::dp_cmd_type         cmd
);
   import fbba_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (mode_type'(req_mode))
                  MODE_INIT: begin
                     state_in = S_INIT;
                  end
                  MODE_ALLOC: begin
                     state_in = stat.no_blocks ? S_FINISH : S_SCAN;
                  end
                  default: begin
                     state_in = stat.in_range ? S_RMW_RD : S_FINISH;
                  end
               endcase
            end
         end
         S_INIT: begin
            cmd.init_step = 1'b1;
            if (stat.init_last) begin
               state_in = S_FINISH;
            end
         end
         S_RMW_RD: begin
            cmd.rmw_read = 1'b1;
            state_in     = S_RMW_WR;
         end
         S_RMW_WR: begin
            cmd.rmw_write = 1'b1;
            state_in      = S_FINISH;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_hit || stat.scan_end) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!stat.out_busy) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ test/free_block_bitmap_allocator_test.sv @@
module free_block_bitmap_allocator_test;
   import fbba_pkg::*;

   typedef struct packed {
      logic [BLK_W-1:0] block;
      status_type       status;
   } alloc_result_type;

   class block_map_tracker;
      logic [MAX_BLOCKS-1:0] used_map = '0;
      logic [CNT_W-1:0]      disk_blocks = CNT_W'(1024);
      logic [CNT_W-1:0]      reserved_blocks = CNT_W'(1);
      alloc_result_type      expected_results[$];
      int                    failures = 0;

      function void write_register(logic [CSR_IDX_W-1:0] index, logic [CNT_W-1:0] data);
         if (index == CSR_DISK_BLOCKS) begin
            disk_blocks = data;
         end else if (index == CSR_RESERVED_BLOCKS) begin
            reserved_blocks = data;
         end
      endfunction

      function int block_limit();
         return (disk_blocks > MAX_BLOCKS) ? MAX_BLOCKS : int'(disk_blocks);
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void note_request(mode_type mode, logic [BLK_W-1:0] blk);
         alloc_result_type res;
         int               lim;
         int               reserve;
         lim = block_limit();
         res.block = '0;
         res.status = STATUS_OK;
         case (mode)
            MODE_INIT: begin
               reserve = (reserved_blocks == 0) ? 1 : int'(reserved_blocks);
               if (reserve > MAX_BLOCKS) begin
                  reserve = MAX_BLOCKS;
               end
               used_map = '0;
               for (int i = 0; i < reserve; i++) begin
                  used_map[i] = 1'b1;
               end
            end
            MODE_ALLOC: begin
               res.status = STATUS_FULL;
               for (int i = 0; i < lim; i++) begin
                  if (!used_map[i]) begin
                     used_map[i] = 1'b1;
                     res.block = BLK_W'(i);
                     res.status = STATUS_OK;
                     break;
                  end
               end
            end
            default: begin
               if (int'(blk) >= lim) begin
                  res.status = STATUS_RANGE;
               end else begin
                  used_map[blk] = (mode == MODE_MARK);
               end
            end
         endcase
         expected_results.push_back(res);
      endfunction

      function void check_response(logic [BLK_W-1:0] blk, logic [STATUS_W-1:0] status);
         alloc_result_type exp_res;
         if (expected_results.size() == 0) begin
            $error("response with no request outstanding: allocated_block %0d, status %0d",
                   blk, status);
            failures++;
            return;
         end
         exp_res = expected_results.pop_front();
         if (blk !== exp_res.block) begin
            $error("allocated_block: expected %0d, actual %0d", exp_res.block, blk);
            failures++;
         end
         if (status !== exp_res.status) begin
            $error("status: expected %0d, actual %0d", exp_res.status, status);
            failures++;
         end
      endfunction
   endclass

   localparam int CYCLE_LIMIT = 600000;
   localparam int IDLE_CYCLES = 40;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 165;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [MODE_W-1:0]     req_mode;
   logic [BLK_W-1:0]      req_block_number;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [BLK_W-1:0]      rsp_allocated_block;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CNT_W-1:0]      csr_data;

   block_map_tracker      tracker;
   bit                    no_idle;
   int                    cycle_count;

   free_block_bitmap_allocator dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_block_number    (req_block_number),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_allocated_block (rsp_allocated_block),
      .rsp_status          (rsp_status),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            tracker.note_request(mode_type'(req_mode), req_block_number);
         end
         if (rsp_valid && !rsp_stall) begin
            tracker.check_response(rsp_allocated_block, rsp_status);
         end
      end
   end

   initial begin
      int hold;
      rsp_stall = 1'b0;
      forever begin
         hold = no_idle ? 0 : $urandom_range(0, 10);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !reset));
      end
   end

   task automatic send_request(mode_type mode, int blk);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_block_number <= BLK_W'(blk);
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // drop the request line and hold until every response is back
   task automatic drain_requests();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(int disk, int reserved);
      csr_valid <= 1'b1;
      csr_index <= CSR_DISK_BLOCKS;
      csr_data <= CNT_W'(disk);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.write_register(CSR_DISK_BLOCKS, CNT_W'(disk));
      csr_index <= CSR_RESERVED_BLOCKS;
      csr_data <= CNT_W'(reserved);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.write_register(CSR_RESERVED_BLOCKS, CNT_W'(reserved));
      csr_valid <= 1'b0;
   endtask

   task automatic send_random_request();
      int       pick;
      int       lim;
      int       blk;
      mode_type mode;
      lim = tracker.block_limit();
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         mode = MODE_ALLOC;
      end else if (pick < 70) begin
         mode = MODE_FREE;
      end else if (pick < 93) begin
         mode = MODE_MARK;
      end else begin
         mode = MODE_INIT;
      end
      if (lim > 0 && $urandom_range(0, 4) != 0) begin
         blk = $urandom_range(0, lim - 1);
      end else begin
         blk = $urandom_range(0, 1023);
      end
      send_request(mode, blk);
   endtask

   initial begin
      int disk_set[PHASES];
      int reserved_set[PHASES];
      tracker = new();
      disk_set = '{1024, 2, 40, 100, 1024, 2047, 0, 300};
      reserved_set = '{1, 1, 5, 64, 1000, 2047, 0, 10};
      cycle_count = 0;
      no_idle = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_INIT;
      req_block_number = '0;
      csr_valid = 1'b0;
      csr_index = CSR_DISK_BLOCKS;
      csr_data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // allocate before any init, then the block number extremes
      send_request(MODE_ALLOC, 0);
      send_request(MODE_ALLOC, 1023);
      send_request(MODE_FREE, 0);
      send_request(MODE_ALLOC, 0);
      send_request(MODE_MARK, 1023);
      send_request(MODE_FREE, 1023);
      send_request(MODE_INIT, 0);
      send_request(MODE_ALLOC, 0);
      drain_requests();

      // oversized disk, zero reserved count
      write_config(2047, 0);
      send_request(MODE_INIT, 1023);
      send_request(MODE_MARK, 1023);
      send_request(MODE_ALLOC, 0);
      send_request(MODE_FREE, 1023);
      drain_requests();

      // empty disk, oversized reserved count
      write_config(0, 2047);
      send_request(MODE_INIT, 0);
      send_request(MODE_ALLOC, 0);
      send_request(MODE_MARK, 5);
      send_request(MODE_FREE, 0);
      drain_requests();

      // two-block disk, fill it and run into the range limit
      write_config(2, 1024);
      send_request(MODE_INIT, 0);
      send_request(MODE_FREE, 1);
      send_request(MODE_ALLOC, 0);
      send_request(MODE_ALLOC, 0);
      send_request(MODE_FREE, 2);
      send_request(MODE_MARK, 1023);
      send_request(MODE_FREE, 0);
      send_request(MODE_ALLOC, 0);
      drain_requests();

      disk_set[PHASES-1] = $urandom_range(0, 2047);
      reserved_set[PHASES-1] = $urandom_range(0, 2047);
      for (int p = 0; p < PHASES; p++) begin
         write_config(disk_set[p], reserved_set[p]);
         no_idle = (p % 3 == 1);
         send_request(MODE_INIT, $urandom_range(0, 1023));
         for (int n = 1; n < PHASE_ITEMS; n++) begin
            send_random_request();
         end
         drain_requests();
      end
      no_idle = 1'b0;

      if (tracker.failures == 0 && tracker.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/fbba_pkg.sv
rtl/fbba_ram.sv
rtl/fbba_datapath.sv
rtl/fbba_ctrl.sv
rtl/free_block_bitmap_allocator.sv
test/free_block_bitmap_allocator_test.sv
